// File: rtl/pbrs_pkg.sv
// Package for the priority bitmap ready scheduler: payload structs, codes, sizes.
// No dependencies.
package pbrs_pkg;
    localparam int NUM_PRIORITIES = 32;
    localparam int NUM_TASKS = 16;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_ALREADY = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  task_id;
        logic [4:0]  priority_req;
        logic [15:0] slice_ticks;
        logic        sched_locked;
    } t_in_word;

    typedef struct packed {
        logic [3:0] running_task;
        logic       any_ready;
        logic [4:0] running_priority;
        logic       yielded;
        logic [1:0] status;
    } t_out_word;
endpackage

// File: rtl/pbrs_front.sv
// Front end: accepts input words into a two-entry queue for the executor.
// Depends on pbrs_pkg.
module pbrs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pbrs_pkg::t_in_word i_word,
    output logic              o_q_valid,
    output pbrs_pkg::t_in_word o_q_word,
    input  logic              i_q_pop
);
    pbrs_pkg::t_in_word r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_word;
                r_wp <= ~r_wp;
            end
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

// File: rtl/pbrs_back.sv
// Executor: list update in S_EXEC, priority encode in S_PICK, result presented in S_OUT.
// Depends on pbrs_pkg.
module pbrs_back #(
    parameter int NUM_PRIORITIES = pbrs_pkg::NUM_PRIORITIES,
    parameter int NUM_TASKS = pbrs_pkg::NUM_TASKS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  pbrs_pkg::t_in_word i_q_word,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output pbrs_pkg::t_out_word o_word
);
    localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    typedef enum logic [1:0] {S_EXEC, S_PICK, S_OUT} t_state;
    t_state r_state;

    logic [NUM_PRIORITIES-1:0] r_mask;
    logic [TW-1:0] r_head [NUM_PRIORITIES];
    logic [TW-1:0] r_tail [NUM_PRIORITIES];
    logic [TW-1:0] r_next [NUM_TASKS];
    logic [TW-1:0] r_prev [NUM_TASKS];
    logic [PW-1:0] r_prio [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_ready;
    logic [15:0] r_left [NUM_TASKS];
    logic [15:0] r_reload [NUM_TASKS];
    logic [TW-1:0] r_cur;
    logic r_yield;
    logic [1:0] r_status;
    pbrs_pkg::t_out_word r_out;

    // combinational helpers
    logic w_any;
    logic [PW-1:0] w_hp;
    always_comb begin
        w_any = 1'b0;
        w_hp = '0;
        for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
            if (r_mask[p]) begin
                w_any = 1'b1;
                w_hp = PW'(p);
            end
        end
    end

    logic [1:0] w_mode;
    logic [TW-1:0] w_t;
    logic w_t_ok;
    logic [PW-1:0] w_p;
    always_comb begin
        w_mode = i_q_word.mode;
        w_t = TW'(i_q_word.task_id);
        w_t_ok = ({1'b0, i_q_word.task_id} < 5'(NUM_TASKS)) || (NUM_TASKS >= 16);
        if ({1'b0, i_q_word.priority_req} >= 6'(NUM_PRIORITIES))
            w_p = PW'(NUM_PRIORITIES - 1);
        else
            w_p = PW'(i_q_word.priority_req);
    end

    assign o_q_pop = (r_state == S_EXEC) && i_q_valid;
    assign o_valid = (r_state == S_OUT);
    assign o_word = r_out;

    always_ff @(posedge i_clk) begin
        logic [TW-1:0] c, u, hd;
        logic [PW-1:0] cp;
        logic [15:0] sl;
        logic uh, ut;
        logic [1:0] st;
        logic yl;
        if (!i_rst_n) begin
            r_state <= S_EXEC;
            r_mask <= '0;
            r_ready <= '0;
            r_cur <= '0;
            for (int i = 0; i < NUM_TASKS; i++) r_left[i] <= '0;
        end else begin
            case (r_state)
                S_EXEC: if (i_q_valid) begin
                    st = pbrs_pkg::ST_OK;
                    yl = 1'b0;
                    case (w_mode)
                        pbrs_pkg::MODE_ADD: if (w_t_ok) begin
                            if (r_ready[w_t]) begin
                                st = pbrs_pkg::ST_ALREADY;
                            end else begin
                                if (!r_mask[w_p]) r_head[w_p] <= w_t;
                                else begin
                                    r_next[r_tail[w_p]] <= w_t;
                                    r_prev[w_t] <= r_tail[w_p];
                                end
                                r_tail[w_p] <= w_t;
                                r_mask[w_p] <= 1'b1;
                                r_prio[w_t] <= w_p;
                                r_ready[w_t] <= 1'b1;
                                r_left[w_t] <= i_q_word.slice_ticks;
                                r_reload[w_t] <= i_q_word.slice_ticks;
                            end
                        end
                        pbrs_pkg::MODE_REMOVE: begin
                            if (!w_t_ok || !r_ready[w_t]) begin
                                st = pbrs_pkg::ST_NOT_READY;
                            end else begin
                                u = w_t;
                                cp = r_prio[u];
                                uh = (r_head[cp] == u);
                                ut = (r_tail[cp] == u);
                                r_ready[u] <= 1'b0;
                                if (uh && ut) r_mask[cp] <= 1'b0;
                                else begin
                                    if (uh) r_head[cp] <= r_next[u];
                                    else r_next[r_prev[u]] <= r_next[u];
                                    if (ut) r_tail[cp] <= r_prev[u];
                                    else r_prev[r_next[u]] <= r_prev[u];
                                end
                            end
                        end
                        pbrs_pkg::MODE_TICK: begin
                            c = r_cur;
                            hd = r_head[w_hp];
                            if (w_any && r_ready[c]) begin
                                cp = r_prio[c];
                                sl = r_left[c];
                                if (sl != 16'd0) sl = sl - 16'd1;
                                if (hd != c) sl = 16'd0;
                                if (sl == 16'd0 && !i_q_word.sched_locked
                                        && r_head[cp] != r_tail[cp]) begin
                                    // rotate to tail; a task already at the tail stays put
                                    if (r_tail[cp] != c) begin
                                        uh = (r_head[cp] == c);
                                        if (uh) r_head[cp] <= r_next[c];
                                        else r_next[r_prev[c]] <= r_next[c];
                                        r_prev[r_next[c]] <= r_prev[c];
                                        r_next[r_tail[cp]] <= c;
                                        r_prev[c] <= r_tail[cp];
                                        r_tail[cp] <= c;
                                    end
                                    sl = r_reload[c];
                                    yl = 1'b1;
                                end
                                r_left[c] <= sl;
                            end
                        end
                        default: ;
                    endcase
                    r_status <= st;
                    r_yield <= yl;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    r_out.yielded <= r_yield;
                    r_out.status <= r_status;
                    r_out.any_ready <= w_any;
                    if (w_any) begin
                        r_cur <= r_head[w_hp];
                        r_out.running_task <= 4'(r_head[w_hp]);
                        r_out.running_priority <= 5'(r_prio[r_head[w_hp]]);
                    end else begin
                        r_out.running_task <= '0;
                        r_out.running_priority <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) r_state <= S_EXEC;
                default: r_state <= S_EXEC;
            endcase
        end
    end
endmodule

// File: rtl/priority_bitmap_ready_scheduler.sv
// Top level of the priority bitmap ready scheduler.
// Depends on pbrs_pkg, pbrs_front, pbrs_back.
//
// Each word passes through the executor states in order: S_EXEC for the queue
// and list update, S_PICK for the find-first-set over the ready bitmap, and
// S_OUT to present the result, which is held for as long as the result side
// stalls; the executor works one word at a time. A two-word input queue lets
// the next words be taken while a result waits.
module priority_bitmap_ready_scheduler #(
    parameter int NUM_PRIORITIES = pbrs_pkg::NUM_PRIORITIES,
    parameter int NUM_TASKS = pbrs_pkg::NUM_TASKS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pbrs_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output pbrs_pkg::t_out_word o_word
);
    logic q_valid, q_pop;
    pbrs_pkg::t_in_word q_word;

    pbrs_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word,
        .o_q_valid(q_valid), .o_q_word(q_word), .i_q_pop(q_pop)
    );

    pbrs_back #(.NUM_PRIORITIES(NUM_PRIORITIES), .NUM_TASKS(NUM_TASKS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_word(q_word), .o_q_pop(q_pop),
        .o_valid, .i_stall, .o_word
    );
endmodule

// File: rtl/pbrs_checker.sv
// Port-level checks for the scheduler, bound to the top level.
// Depends on pbrs_pkg.
module pbrs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input pbrs_pkg::t_out_word o_word
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word)) else $error("result moved");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.any_ready |-> o_word.running_task == 4'd0
        && o_word.running_priority == 5'd0 && !o_word.yielded) else $error("idle result");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_word.status <= pbrs_pkg::ST_ALREADY) else $error("bad status");
    a_ystat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.yielded |-> o_word.status == pbrs_pkg::ST_OK
        && o_word.any_ready) else $error("yield with error");
endmodule

bind priority_bitmap_ready_scheduler pbrs_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_word
);
